@@ hdl/sra_pkg.sv @@
// Shared types and constants for the sparse row accumulator.
// No dependencies.
package sra_pkg;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_DIV    = 3'd2,
    CMD_TAKE   = 3'd3,
    CMD_READ   = 3'd4,
    CMD_PRUNE  = 3'd5,
    CMD_RSVD6  = 3'd6,
    CMD_RSVD7  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  localparam int unsigned CmdBits    = 3;
  localparam int unsigned PosWidth   = 16;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 7;
  localparam int unsigned ThreshBits = 31;

  localparam logic [0:0] RegPruneThreshold = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DIV,
    S_PR_RD,
    S_PR_WAIT,
    S_PR_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CmdBits-1:0]   cmd;
    logic [PosWidth-1:0]  position;
    logic [ValueBits-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [ValueBits-1:0]  read_value;
    logic [StatusBits-1:0] status;
    logic [CountBits-1:0]  entry_count;
  } rsp_t;

endpackage

@@ hdl/sra_if.sv @@
// Valid/ready channel carrying one item of type T.
// Depends on nothing; instantiated with sra_pkg types.
interface sra_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/sparse_row_accumulator_top.sv @@
// Sparse row accumulator top level: sequencer, entry RAMs, divider, APB register.
// Depends on sra_pkg, sra_if, sra_ram, sra_div.
// Per item: a scan of the sorted entries, then entry moves on insert or a divide; prune passes over
//   every entry; reserved codes and divide by zero skip straight to the result.
// Throughput: one item at a time; ready is low from accept until the result is registered.
// Reset: entry count cleared, prune threshold set to 1; entry RAM contents are not cleared.
module sparse_row_accumulator_top #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sra_if.sink         in_if,
  sra_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sra_pkg::*;

  localparam int unsigned IdxBits = $clog2(CAPACITY);
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  rsp_t                   rsp_q, rsp_d;
  rsp_t                   out_q, out_d;
  logic                   ovalid_q, ovalid_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        wp_q, wp_d;
  logic [ThreshBits-1:0]  thresh_q;
  logic [ValueBits-1:0]   hold_val_q, hold_val_d;
  logic [POSITION_BITS-1:0] hold_pos_q, hold_pos_d;

  logic                   pos_we, val_we;
  logic [IdxBits-1:0]     waddr, raddr;
  logic [POSITION_BITS-1:0] pos_wdata, pos_rdata, req_pos;
  logic [ValueBits-1:0]   val_wdata, val_rdata;
  logic                   div_start, div_done;
  logic signed [ValueBits-1:0] div_quot;
  logic [ValueBits:0]     sum_w;
  logic [ValueBits-1:0]   sum_sat, mag;
  logic                   hit;

  sra_ram #(.Width(POSITION_BITS), .Depth(CAPACITY)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(waddr), .wdata_i(pos_wdata),
    .raddr_i(raddr), .rdata_o(pos_rdata)
  );

  sra_ram #(.Width(ValueBits), .Depth(CAPACITY)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(waddr), .wdata_i(val_wdata),
    .raddr_i(raddr), .rdata_o(val_rdata)
  );

  sra_div #(.FracBits(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(val_rdata), .den_i(req_q.operand),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, thresh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshBits'(1);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      thresh_q <= pwdata[ThreshBits-1:0];
    end
  end

  assign req_pos   = req_q.position[POSITION_BITS-1:0];
  assign hit       = (pos_rdata == req_pos);
  assign sum_w     = {val_rdata[ValueBits-1], val_rdata} +
                     {req_q.operand[ValueBits-1], req_q.operand};
  assign sum_sat   = (sum_w[ValueBits] != sum_w[ValueBits-1]) ?
                     (sum_w[ValueBits] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_w[ValueBits-1:0];
  assign mag       = val_rdata[ValueBits-1] ? ValueBits'(-val_rdata) : val_rdata;

  assign in_if.ready    = (state_q == S_IDLE);
  assign out_if.valid   = ovalid_q;
  assign out_if.payload = out_q;

  always_comb begin
    state_d = state_q; req_d = req_q; rsp_d = rsp_q; ovalid_d = ovalid_q;
    out_d = out_q;
    count_d = count_q; idx_d = idx_q; wp_d = wp_q;
    hold_val_d = hold_val_q; hold_pos_d = hold_pos_q;
    pos_we = 1'b0; val_we = 1'b0;
    waddr = idx_q[IdxBits-1:0]; raddr = idx_q[IdxBits-1:0];
    pos_wdata = req_pos; val_wdata = req_q.operand;
    div_start = 1'b0;

    if (ovalid_q && out_if.ready) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          req_d = in_if.payload;
          rsp_d = '{read_value: '0, status: ST_OK, entry_count: '0};
          idx_d = '0;
          wp_d  = '0;
          if (in_if.payload.cmd == CMD_PRUNE) begin
            state_d = S_PR_RD;
          end else if (in_if.payload.cmd == CMD_DIV && in_if.payload.operand == '0) begin
            rsp_d.status = ST_DIV0;
            state_d = S_DONE;
          end else if (in_if.payload.cmd == CMD_RSVD6 || in_if.payload.cmd == CMD_RSVD7) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= count_q) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        if (pos_rdata < req_pos) begin
          idx_d = idx_q + 1'b1;
          raddr = IdxBits'(idx_q + 1'b1);
          state_d = S_SCAN;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // rdata still holds entry idx when idx < count
        if (idx_q < count_q && hit) begin
          unique case (req_q.cmd)
            CMD_SET:  begin val_we = 1'b1; state_d = S_DONE; end
            CMD_ADD:  begin val_we = 1'b1; val_wdata = sum_sat; state_d = S_DONE; end
            CMD_DIV:  begin div_start = 1'b1; state_d = S_DIV; end
            CMD_TAKE: begin
              rsp_d.read_value = val_rdata;
              val_we = 1'b1; val_wdata = '0; state_d = S_DONE;
            end
            default:  begin rsp_d.read_value = val_rdata; state_d = S_DONE; end
          endcase
        end else if (req_q.cmd == CMD_SET || req_q.cmd == CMD_ADD) begin
          if (count_q == CntW'(CAPACITY)) begin
            rsp_d.status = ST_FULL;
            state_d = S_DONE;
          end else begin
            wp_d = count_q;
            state_d = S_SHIFT_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        if (wp_q == idx_q) begin
          pos_we = 1'b1; val_we = 1'b1;
          waddr = idx_q[IdxBits-1:0];
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end else begin
          raddr = IdxBits'(wp_q - 1'b1);
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        pos_we = 1'b1; val_we = 1'b1;
        waddr = wp_q[IdxBits-1:0];
        pos_wdata = pos_rdata; val_wdata = val_rdata;
        wp_d = wp_q - 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_DIV: begin
        if (div_done) begin
          val_we = 1'b1; val_wdata = div_quot;
          state_d = S_DONE;
        end
      end
      S_PR_RD: begin
        if (idx_q >= count_q) begin
          count_d = wp_q;
          state_d = S_DONE;
        end else begin
          state_d = S_PR_WAIT;
        end
      end
      S_PR_WAIT: begin
        hold_pos_d = pos_rdata;
        hold_val_d = val_rdata;
        state_d = S_PR_CHK;
      end
      S_PR_CHK: begin
        if ({1'b0, mag} > {2'b0, thresh_q}) begin
          pos_we = 1'b1; val_we = 1'b1;
          waddr = wp_q[IdxBits-1:0];
          pos_wdata = hold_pos_q; val_wdata = hold_val_q;
          wp_d = wp_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        raddr = IdxBits'(idx_q + 1'b1);
        state_d = S_PR_RD;
      end
      S_DONE: begin
        if (!ovalid_q || out_if.ready) begin
          out_d = '{read_value: rsp_q.read_value, status: rsp_q.status,
                    entry_count: CountBits'(count_q)};
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      count_q  <= '0;
      idx_q    <= '0;
      wp_q     <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      wp_q     <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rsp_q      <= rsp_d;
    out_q      <= out_d;
    hold_val_q <= hold_val_d;
    hold_pos_q <= hold_pos_d;
  end
endmodule

@@ hdl/sra_ram.sv @@
// Generic simple dual-port RAM (separate write and read ports), one write and one read per cycle, registered read.
// No dependencies.
module sra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/sra_div.sv @@
// Restoring divider, one quotient bit per cycle, signed Q-format result saturated to 32 bits.
// Depends on sra_pkg.
module sra_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [sra_pkg::ValueBits-1:0] num_i,
  input  logic signed [sra_pkg::ValueBits-1:0] den_i,
  output logic                              done_o,
  output logic signed [sra_pkg::ValueBits-1:0] quot_o
);
  import sra_pkg::*;

  localparam int unsigned NumBits = ValueBits + FracBits;
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0]   n_q, n_d;
  logic [ValueBits:0]   r_q, r_d;
  logic [ValueBits-1:0] dv_q, dv_d;
  logic                 neg_q, neg_d;
  logic                 busy_q, busy_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [ValueBits:0]   shifted, diff;
  logic [ValueBits-1:0] num_mag, den_mag;
  logic [NumBits-1:0]   qmag;
  logic [NumBits:0]     qsigned;

  assign num_mag = num_i[ValueBits-1] ? ValueBits'(-num_i) : ValueBits'(num_i);
  assign den_mag = den_i[ValueBits-1] ? ValueBits'(-den_i) : ValueBits'(den_i);
  assign shifted = {r_q[ValueBits-1:0], n_q[NumBits-1]};
  assign diff    = shifted - {1'b0, dv_q};

  always_comb begin
    n_d = n_q; r_d = r_q; dv_d = dv_q; neg_d = neg_q; busy_d = busy_q; cnt_d = cnt_q;
    done_o = 1'b0;
    if (start_i) begin
      n_d    = NumBits'(num_mag) << FracBits;
      r_d    = '0;
      dv_d   = den_mag;
      neg_d  = num_i[ValueBits-1] ^ den_i[ValueBits-1];
      busy_d = 1'b1;
      cnt_d  = CntBits'(NumBits);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (!diff[ValueBits]) begin
          r_d = diff;
          n_d = {n_q[NumBits-2:0], 1'b1};
        end else begin
          r_d = shifted;
          n_d = {n_q[NumBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign qmag    = n_q;
  assign qsigned = neg_q ? -{1'b0, qmag} : {1'b0, qmag};

  always_comb begin
    if (!neg_q && (qmag > NumBits'(32'h7FFF_FFFF))) begin
      quot_o = 32'sh7FFF_FFFF;
    end else if (neg_q && (qmag > NumBits'(33'h8000_0000))) begin
      quot_o = 32'sh8000_0000;
    end else begin
      quot_o = qsigned[ValueBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; dv_q <= dv_d; neg_q <= neg_d;
  end
endmodule

@@ test/tb_sparse_row_accumulator_top.sv @@
// Self-checking testbench for sparse_row_accumulator_top: directed table, then random commands.
// Depends on sra_pkg, sra_if and the block's RTL; predicts results with its own sorted-row model.
`timescale 1ns / 100ps

module tb_sparse_row_accumulator_top;
  import sra_pkg::*;

  localparam int unsigned Cap = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sra_if #(.T(req_t)) cmd_if ();
  sra_if #(.T(rsp_t)) res_if ();

  sparse_row_accumulator_top u_top (
    .clk_i, .rst_ni, .in_if(cmd_if.sink), .out_if(res_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // row model
  logic [15:0] row_pos[Cap];
  logic signed [31:0] row_val[Cap];
  int unsigned row_count;
  logic [30:0] prune_thresh;

  rsp_t expected_q[$];
  int unsigned mismatches = 0;
  bit stall_req = 1'b0;
  bit stall_on = 1'b0;
  bit draining = 1'b0;

  typedef struct {
    cmd_e cmd;
    logic [15:0] position;
    logic [31:0] operand;
    bit fixed;
    rsp_t result;
  } row_t;

  function automatic logic signed [31:0] sat32(logic signed [64:0] v);
    if (v > 65'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -65'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rsp_t predict_row(req_t r);
    rsp_t o;
    int unsigned i, j;
    bit hit;
    logic signed [31:0] opnd;
    logic signed [63:0] num, mag;
    opnd = r.operand;
    o.read_value = '0;
    o.status = ST_OK;
    i = 0;
    while (i < row_count && row_pos[i] < r.position) i++;
    hit = (i < row_count) && (row_pos[i] == r.position);
    case (cmd_e'(r.cmd))
      CMD_SET, CMD_ADD: begin
        if (hit) begin
          if (r.cmd == CMD_SET) row_val[i] = opnd;
          else row_val[i] = sat32(65'(row_val[i]) + 65'(opnd));
        end else if (row_count >= Cap) begin
          o.status = ST_FULL;
        end else begin
          for (j = row_count; j > i; j--) begin
            row_pos[j] = row_pos[j-1];
            row_val[j] = row_val[j-1];
          end
          row_pos[i] = r.position;
          row_val[i] = opnd;
          row_count++;
        end
      end
      CMD_DIV: begin
        if (opnd == 0) o.status = ST_DIV0;
        else if (hit) begin
          num = 64'(row_val[i]) <<< 16;
          row_val[i] = sat32(65'(num / 64'(opnd)));
        end
      end
      CMD_TAKE, CMD_READ: begin
        if (hit) begin
          o.read_value = row_val[i];
          if (r.cmd == CMD_TAKE) row_val[i] = '0;
        end
      end
      CMD_PRUNE: begin
        j = 0;
        for (i = 0; i < row_count; i++) begin
          mag = row_val[i] < 0 ? -64'(row_val[i]) : 64'(row_val[i]);
          if (mag > 64'(prune_thresh)) begin
            row_pos[j] = row_pos[i];
            row_val[j] = row_val[i];
            j++;
          end
        end
        row_count = j;
      end
      default: ;
    endcase
    o.entry_count = 7'(row_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // long receiver hold-off, counted here
  initial begin
    wait (stall_req);
    stall_on = 1'b1;
    repeat (400) @(posedge clk_i);
    stall_on = 1'b0;
  end

  // result checker and stall pattern
  always @(posedge clk_i) begin
    rsp_t e;
    if (res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", res_if.payload.read_value, '0);
      end else begin
        e = expected_q.pop_front();
        if (res_if.payload.read_value !== e.read_value)
          report_mismatch("read_value", res_if.payload.read_value, e.read_value);
        if (res_if.payload.status !== e.status)
          report_mismatch("status", 32'(res_if.payload.status), 32'(e.status));
        if (res_if.payload.entry_count !== e.entry_count)
          report_mismatch("entry_count", 32'(res_if.payload.entry_count), 32'(e.entry_count));
      end
    end
    if (!rst_ni) res_if.ready <= 1'b0;
    else if (stall_on) res_if.ready <= 1'b0;
    else if (draining) res_if.ready <= 1'b1;
    else res_if.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    prune_thresh = data[30:0];
    @(posedge clk_i);
    if (prdata !== {1'b0, prune_thresh})
      report_mismatch("prdata", prdata, {1'b0, prune_thresh});
  endtask

  int burst_left = 0;

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic send_cmd(cmd_e c, logic [15:0] p, logic [31:0] v, output rsp_t pred);
    req_t r;
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    r.cmd = c; r.position = p; r.operand = v;
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= r;
    do @(posedge clk_i); while (!cmd_if.ready);
    pred = predict_row(r);
    expected_q.push_back(pred);
    burst_left--;
    if (burst_left == 0) cmd_if.valid <= 1'b0;
  endtask

  task automatic random_cmd(int unsigned pos_span);
    rsp_t p;
    cmd_e c;
    logic [31:0] v;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30) c = CMD_SET;
    else if (k < 55) c = CMD_ADD;
    else if (k < 65) c = CMD_DIV;
    else if (k < 75) c = CMD_TAKE;
    else if (k < 88) c = CMD_READ;
    else if (k < 96) c = CMD_PRUNE;
    else c = cmd_e'($urandom_range(6, 7));
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = $urandom_range(0, 3);
      2: v = -$urandom_range(0, 3);
      3: v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: v = 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 16;
    endcase
    if (c == CMD_DIV && $urandom_range(0, 4) != 0 && v == 0) v = 32'h0001_0000;
    send_cmd(c, (pos_span == 0) ? 16'($urandom()) : 16'($urandom_range(0, pos_span)), v, p);
  endtask

  row_t dir_tab[$];

  initial begin
    rsp_t p;
    cmd_if.valid = 1'b0;
    cmd_if.payload = '0;
    row_count = 0;
    prune_thresh = 31'd1;
    dir_tab = '{
      '{CMD_READ, 16'd5, 32'd0, 1, '{32'd0, ST_OK, 7'd0}},
      '{CMD_DIV, 16'd5, 32'd0, 1, '{32'd0, ST_DIV0, 7'd0}},
      '{CMD_DIV, 16'd5, 32'd7, 1, '{32'd0, ST_OK, 7'd0}},
      '{CMD_TAKE, 16'd5, 32'd0, 1, '{32'd0, ST_OK, 7'd0}},
      '{CMD_ADD, 16'd0, 32'd0, 1, '{32'd0, ST_OK, 7'd1}},
      '{CMD_SET, 16'hFFFF, 32'h7FFFFFFF, 1, '{32'd0, ST_OK, 7'd2}},
      '{CMD_ADD, 16'hFFFF, 32'h7FFFFFFF, 0, '{0, ST_OK, 0}},
      '{CMD_READ, 16'hFFFF, 32'd0, 1, '{32'h7FFFFFFF, ST_OK, 7'd2}},
      '{CMD_SET, 16'h8000, 32'h80000000, 0, '{0, ST_OK, 0}},
      '{CMD_ADD, 16'h8000, 32'hFFFFFFFF, 0, '{0, ST_OK, 0}},
      '{CMD_DIV, 16'h8000, 32'h0000_8000, 0, '{0, ST_OK, 0}},
      '{CMD_DIV, 16'hFFFF, 32'hFFFFFFFF, 0, '{0, ST_OK, 0}},
      '{CMD_DIV, 16'h8000, 32'h0000_0000, 1, '{32'd0, ST_DIV0, 7'd3}},
      '{CMD_SET, 16'h0100, 32'h0003_0000, 0, '{0, ST_OK, 0}},
      '{CMD_DIV, 16'h0100, 32'hFFFE_0000, 0, '{0, ST_OK, 0}},
      '{CMD_TAKE, 16'h0100, 32'd0, 0, '{0, ST_OK, 0}},
      '{CMD_READ, 16'h0100, 32'd0, 1, '{32'd0, ST_OK, 7'd4}},
      '{CMD_RSVD6, 16'h1234, 32'h5A5A5A5A, 1, '{32'd0, ST_OK, 7'd4}},
      '{CMD_RSVD7, 16'hEDCB, 32'hA5A5A5A5, 1, '{32'd0, ST_OK, 7'd4}},
      '{CMD_SET, 16'h0200, 32'hFFFFFFFF, 0, '{0, ST_OK, 0}},
      '{CMD_PRUNE, 16'h0, 32'd0, 0, '{0, ST_OK, 0}},
      '{CMD_READ, 16'h8000, 32'd0, 0, '{0, ST_OK, 0}}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) begin
      send_cmd(dir_tab[n].cmd, dir_tab[n].position, dir_tab[n].operand, p);
      if (dir_tab[n].fixed && p != dir_tab[n].result)
        report_mismatch("directed row", 32'(n), 32'(p.entry_count));
    end
    wait_idle();

    // fill to capacity, then hit the full case with the receiver held off
    for (int n = 0; n < Cap; n++)
      send_cmd(CMD_SET, 16'(n * 997 + 3), 32'($urandom()) | 32'h0010_0000, p);
    stall_req = 1'b1;
    for (int n = 0; n < 6; n++) random_cmd(0);
    send_cmd(CMD_ADD, 16'd1, 32'd9, p);
    wait_idle();

    apb_write(2'(4 * RegPruneThreshold), 32'h7FFFFFFF);
    for (int n = 0; n < 80; n++) random_cmd(255);
    send_cmd(CMD_PRUNE, '0, '0, p);
    wait_idle();
    apb_write(2'(4 * RegPruneThreshold), 32'd0);
    for (int n = 0; n < 250; n++) random_cmd(($urandom_range(0, 3) == 0) ? 0 : 127);
    wait_idle();
    apb_write(2'(4 * RegPruneThreshold), 32'h0002_0000);
    for (int n = 0; n < 300; n++) random_cmd(($urandom_range(0, 3) == 0) ? 0 : 95);
    cmd_if.valid <= 1'b0;
    draining = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) $display("sparse_row_accumulator_top verification clean");
    else $display("sparse_row_accumulator_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("sparse_row_accumulator_top verification failed");
    $finish;
  end
endmodule
